// File: sv/abb_pkg.sv
// ----------------------------------------------------------------------------
// abb_pkg : shared types, constants and functions for the arc bounding box
// Arctangent table in 2^-24 turn, CORDIC gain, fixed widths, stage record.
// ----------------------------------------------------------------------------
package abb_pkg;

  localparam int CoordBits = 16;
  localparam int Stages = 16;
  localparam int ShiftBits = $clog2(Stages);
  localparam int VecBits = 36;   // 18-bit difference times 2^14 plus growth
  localparam int ZBits = 26;     // angle accumulator, 2^-24 turn
  localparam int RotBits = 34;   // Q2.30 rotation datapath
  localparam int ExtBits = 20;   // widened coordinate
  localparam logic signed [ZBits-1:0] TurnHalf = 26'sd8388608;
  localparam logic signed [RotBits-1:0] CordicK = 34'sd652032874;

  // shape kinds; the spare code 3 behaves as an arc
  localparam logic [1:0] FnArc = 2'd0;
  localparam logic [1:0] FnChord = 2'd1;
  localparam logic [1:0] FnPie = 2'd2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [ExtBits-1:0] ext_t;
  typedef logic signed [VecBits-1:0] vec_t;
  typedef logic signed [ZBits-1:0] ang_t;
  typedef logic signed [RotBits-1:0] rot_t;
  typedef logic [ShiftBits-1:0] shift_t;

  function automatic ang_t atan_turn(input int i);
    ang_t t;
    case (i)
      0: t = 26'sd2097152;  1: t = 26'sd1238021;  2: t = 26'sd654136;
      3: t = 26'sd332050;   4: t = 26'sd166669;   5: t = 26'sd83416;
      6: t = 26'sd41718;    7: t = 26'sd20860;    8: t = 26'sd10430;
      9: t = 26'sd5215;     10: t = 26'sd2608;    11: t = 26'sd1304;
      12: t = 26'sd652;     13: t = 26'sd326;     14: t = 26'sd163;
      15: t = 26'sd81;      16: t = 26'sd41;      17: t = 26'sd20;
      18: t = 26'sd10;      19: t = 26'sd5;       20: t = 26'sd3;
      21: t = 26'sd1;       22: t = 26'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Everything a request carries down the row besides the CORDIC vectors, angles, zero flags and quadrant words.
  typedef struct packed {
    logic ok;
    logic pie;
    ext_t l;
    ext_t t;
    ext_t r;
    ext_t b;
    ext_t xc;
    ext_t yc;
    ext_t hx;
    ext_t hy;
  } geo_t;

endpackage

// File: sv/abb_vec_cell.sv
// ----------------------------------------------------------------------------
// abb_vec_cell : one vectoring CORDIC stage, two vectors side by side
// Rotates each vector towards +x and accumulates its angle.
// ----------------------------------------------------------------------------
module abb_vec_cell (
  input  logic                clk,
  input  logic                en,
  input  abb_pkg::shift_t     shift,
  input  abb_pkg::vec_t [1:0] x_in,
  input  abb_pkg::vec_t [1:0] y_in,
  input  abb_pkg::ang_t [1:0] z_in,
  input  abb_pkg::geo_t       geo_in,
  output abb_pkg::vec_t [1:0] x_out,
  output abb_pkg::vec_t [1:0] y_out,
  output abb_pkg::ang_t [1:0] z_out,
  output abb_pkg::geo_t       geo_out
);

  always_ff @(posedge clk) begin
    if (en) begin
      geo_out <= geo_in;
      for (int k = 0; k < 2; k++) begin
        if (!y_in[k][abb_pkg::VecBits-1]) begin
          x_out[k] <= x_in[k] + (y_in[k] >>> shift);
          y_out[k] <= y_in[k] - (x_in[k] >>> shift);
          z_out[k] <= z_in[k] + abb_pkg::atan_turn(int'(shift));
        end else begin
          x_out[k] <= x_in[k] - (y_in[k] >>> shift);
          y_out[k] <= y_in[k] + (x_in[k] >>> shift);
          z_out[k] <= z_in[k] - abb_pkg::atan_turn(int'(shift));
        end
      end
    end
  end

endmodule

// File: sv/abb_rot_cell.sv
// ----------------------------------------------------------------------------
// abb_rot_cell : one rotation CORDIC stage, two vectors side by side
// Drives the residual angle to zero, giving cosine and sine.
// ----------------------------------------------------------------------------
module abb_rot_cell (
  input  logic                clk,
  input  logic                en,
  input  abb_pkg::shift_t     shift,
  input  abb_pkg::rot_t [1:0] x_in,
  input  abb_pkg::rot_t [1:0] y_in,
  input  abb_pkg::ang_t [1:0] z_in,
  input  logic [1:0][1:0]     q_in,
  input  logic [1:0][15:0]    a_in,
  input  abb_pkg::geo_t       geo_in,
  output abb_pkg::rot_t [1:0] x_out,
  output abb_pkg::rot_t [1:0] y_out,
  output abb_pkg::ang_t [1:0] z_out,
  output logic [1:0][1:0]     q_out,
  output logic [1:0][15:0]    a_out,
  output abb_pkg::geo_t       geo_out
);

  always_ff @(posedge clk) begin
    if (en) begin
      geo_out <= geo_in;
      q_out <= q_in;
      a_out <= a_in;
      for (int k = 0; k < 2; k++) begin
        if (!z_in[k][abb_pkg::ZBits-1]) begin
          x_out[k] <= x_in[k] - (y_in[k] >>> shift);
          y_out[k] <= y_in[k] + (x_in[k] >>> shift);
          z_out[k] <= z_in[k] - abb_pkg::atan_turn(int'(shift));
        end else begin
          x_out[k] <= x_in[k] + (y_in[k] >>> shift);
          y_out[k] <= y_in[k] - (x_in[k] >>> shift);
          z_out[k] <= z_in[k] + abb_pkg::atan_turn(int'(shift));
        end
      end
    end
  end

endmodule

// File: sv/arc_bounding_box.sv
// ----------------------------------------------------------------------------
// arc_bounding_box : bounding box of an arc, chord or pie request
// Orders the rectangle, finds centre and angles by vectoring CORDIC, sine
// and cosine by rotation CORDIC, then the intercept box and quadrant growth.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  in        in   in_valid/in_stall  func, rect_*, start_*, end_*
//  out       out  out_valid/out_stall ok, box_*
//  config    in   cfg_we             cfg_data (compatible_mode)
//
// A request enters every cycle the row is not held. The row has two
// setup stages (corner order and centre, then vectors and half-turn
// fold), one cell per vectoring stage, one per rotation stage, then
// intercept multiply, divide, box and output register. The whole row
// advances together; a stalled output with a full output register
// holds every stage. rst clears valid flags and the mode register
// (to 1).
module arc_bounding_box (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic signed [15:0] rect_left,
  input  logic signed [15:0] rect_top,
  input  logic signed [15:0] rect_right,
  input  logic signed [15:0] rect_bottom,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic        cfg_we,
  input  logic        cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic signed [15:0] box_left,
  output logic signed [15:0] box_top,
  output logic signed [15:0] box_right,
  output logic signed [15:0] box_bottom
);

  localparam int Depth = 2 + 2 * abb_pkg::Stages + 4;
  localparam int NS = abb_pkg::Stages;

  logic compatible_mode;
  logic [Depth-1:0] vld;
  logic adv;

  // the row moves when the output slot is free or being taken
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      compatible_mode <= 1'b1;
      vld <= '0;
    end else begin
      if (cfg_we) compatible_mode <= cfg_data;
      if (adv) vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // ---- stage 0: order corners, centre, half sizes
  abb_pkg::geo_t g0;
  abb_pkg::ext_t s0_sx, s0_sy, s0_ex, s0_ey;

  always_ff @(posedge clk) begin
    abb_pkg::ext_t l, t, r, b;
    if (adv) begin
      l = abb_pkg::ext_t'(rect_left);
      r = abb_pkg::ext_t'(rect_right);
      t = abb_pkg::ext_t'(rect_top);
      b = abb_pkg::ext_t'(rect_bottom);
      if (l > r) begin l = abb_pkg::ext_t'(rect_right); r = abb_pkg::ext_t'(rect_left); end
      if (t > b) begin t = abb_pkg::ext_t'(rect_bottom); b = abb_pkg::ext_t'(rect_top); end
      if (compatible_mode) begin r = r - 20'sd1; b = b - 20'sd1; end
      g0.ok <= (rect_left != rect_right) && (rect_top != rect_bottom);
      g0.pie <= (func == abb_pkg::FnPie);
      g0.l <= l; g0.t <= t; g0.r <= r; g0.b <= b;
      g0.xc <= (l + r + 20'sd1) / 20'sd2;
      g0.yc <= (t + b + 20'sd1) / 20'sd2;
      g0.hx <= (r - l + 20'sd1) >>> 1;
      g0.hy <= (b - t + 20'sd1) >>> 1;
      s0_sx <= abb_pkg::ext_t'(start_x);
      s0_sy <= abb_pkg::ext_t'(start_y);
      s0_ex <= abb_pkg::ext_t'(end_x);
      s0_ey <= abb_pkg::ext_t'(end_y);
    end
  end

  // ---- stage 1: vectors, half-turn fold, prescale
  abb_pkg::vec_t [1:0] vx0;
  abb_pkg::vec_t [1:0] vy0;
  abb_pkg::ang_t [1:0] vz0;
  abb_pkg::geo_t vg [NS+1];
  logic [1:0] vzero0;

  always_ff @(posedge clk) begin
    abb_pkg::ext_t dx [2];
    abb_pkg::ext_t dy [2];
    if (adv) begin
      dx[0] = s0_sx - g0.xc; dy[0] = g0.yc - s0_sy;
      dx[1] = s0_ex - g0.xc; dy[1] = g0.yc - s0_ey;
      vg[0] <= g0;
      for (int k = 0; k < 2; k++) begin
        vzero0[k] <= (dx[k] == 0) && (dy[k] == 0);
        if (dx[k] < 0) begin
          vx0[k] <= abb_pkg::vec_t'(-dx[k]) <<< 14;
          vy0[k] <= abb_pkg::vec_t'(-dy[k]) <<< 14;
          vz0[k] <= abb_pkg::TurnHalf;
        end else begin
          vx0[k] <= abb_pkg::vec_t'(dx[k]) <<< 14;
          vy0[k] <= abb_pkg::vec_t'(dy[k]) <<< 14;
          vz0[k] <= '0;
        end
      end
    end
  end

  // packed pairs down the vectoring row
  abb_pkg::vec_t [1:0] vxp [NS+1];
  abb_pkg::vec_t [1:0] vyp [NS+1];
  abb_pkg::ang_t [1:0] vzp [NS+1];
  logic [1:0] vzero_d [NS+1];

  assign vxp[0] = vx0;
  assign vyp[0] = vy0;
  assign vzp[0] = vz0;
  assign vzero_d[0] = vzero0;

  for (genvar i = 0; i < NS; i++) begin : g_vec
    abb_vec_cell u_cell (
      .clk(clk), .en(adv), .shift(abb_pkg::shift_t'(i)),
      .x_in(vxp[i]), .y_in(vyp[i]), .z_in(vzp[i]), .geo_in(vg[i]),
      .x_out(vxp[i+1]), .y_out(vyp[i+1]), .z_out(vzp[i+1]), .geo_out(vg[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) vzero_d[i+1] <= vzero_d[i];
    end
  end

  // ---- rotation start: round angle, quadrant split
  abb_pkg::rot_t [1:0] rxp [NS+1];
  abb_pkg::rot_t [1:0] ryp [NS+1];
  abb_pkg::ang_t [1:0] rzp [NS+1];
  logic [1:0][1:0] rq [NS+1];
  logic [1:0][15:0] ra [NS+1];
  abb_pkg::geo_t rg [NS+1];

  always_comb begin
    logic [15:0] a;
    abb_pkg::ang_t zr;
    rg[0] = vg[NS];
    for (int k = 0; k < 2; k++) begin
      zr = vzp[NS][k] + abb_pkg::ang_t'(128);
      a = vzero_d[NS][k] ? 16'd0 : zr[23:8];
      ra[0][k] = a;
      rq[0][k] = a[15:14];
      rxp[0][k] = abb_pkg::CordicK;
      ryp[0][k] = '0;
      rzp[0][k] = abb_pkg::ang_t'({a[13:0], 8'd0});
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    abb_rot_cell u_cell (
      .clk(clk), .en(adv), .shift(abb_pkg::shift_t'(i)),
      .x_in(rxp[i]), .y_in(ryp[i]), .z_in(rzp[i]), .q_in(rq[i]), .a_in(ra[i]),
      .geo_in(rg[i]),
      .x_out(rxp[i+1]), .y_out(ryp[i+1]), .z_out(rzp[i+1]), .q_out(rq[i+1]),
      .a_out(ra[i+1]), .geo_out(rg[i+1])
    );
  end

  // ---- intercept products
  function automatic logic signed [16:0] to_q15(input abb_pkg::rot_t v);
    abb_pkg::rot_t s;
    s = (v + abb_pkg::rot_t'(16384)) >>> 15;
    if (s > 32767) return 17'sd32767;
    if (s < -32767) return -17'sd32767;
    return s[16:0];
  endfunction

  logic signed [38:0] px [2];
  logic signed [38:0] py [2];
  logic [15:0] pa [2];
  abb_pkg::geo_t pg;

  always_ff @(posedge clk) begin
    logic signed [16:0] cc, ss, c, s;
    if (adv) begin
      pg <= rg[NS];
      for (int k = 0; k < 2; k++) begin
        cc = to_q15(rxp[NS][k]);
        ss = to_q15(ryp[NS][k]);
        case (rq[NS][k])
          2'd0: begin c = cc;  s = ss;  end
          2'd1: begin c = -ss; s = cc;  end
          2'd2: begin c = -cc; s = -ss; end
          default: begin c = ss; s = -cc; end
        endcase
        pa[k] <= ra[NS][k];
        px[k] <= 39'(rg[NS].hx * c) + (39'(rg[NS].xc) <<< 15);
        py[k] <= 39'(-(rg[NS].hy * s)) + (39'(rg[NS].yc) <<< 15);
      end
    end
  end

  // ---- truncating divide by 2^15
  abb_pkg::ext_t xi [2];
  abb_pkg::ext_t yi [2];
  logic [15:0] qa [2];
  abb_pkg::geo_t qg;

  function automatic abb_pkg::ext_t div15(input logic signed [38:0] v);
    logic signed [38:0] w;
    w = v[38] ? v + 39'sd32767 : v;
    return abb_pkg::ext_t'(w >>> 15);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      qg <= pg;
      for (int k = 0; k < 2; k++) begin
        xi[k] <= div15(px[k]);
        yi[k] <= div15(py[k]);
        qa[k] <= pa[k];
      end
    end
  end

  // ---- box, quadrant growth, pie centre
  abb_pkg::ext_t bl, bt, br, bb;
  abb_pkg::geo_t bg;

  always_ff @(posedge clk) begin
    abb_pkg::ext_t l, t, r, b;
    logic [17:0] st, en, bnd;
    if (adv) begin
      bg <= qg;
      l = (xi[0] < xi[1]) ? xi[0] : xi[1];
      r = (xi[0] > xi[1]) ? xi[0] : xi[1];
      t = (yi[0] < yi[1]) ? yi[0] : yi[1];
      b = (yi[0] > yi[1]) ? yi[0] : yi[1];
      st = {2'b00, qa[0]};
      en = {2'b00, qa[1]};
      if (en < st) en = en + 18'd65536;
      for (int i = 0; i <= 8; i++) begin
        bnd = 18'(i) << 14;
        if (bnd >= st && bnd <= en) begin
          case (i % 4)
            0: r = qg.r;
            1: t = qg.t;
            2: l = qg.l;
            default: b = qg.b;
          endcase
        end
      end
      if (qg.pie) begin
        if (l > qg.xc) l = qg.xc;
        else if (r < qg.xc) r = qg.xc;
        if (t > qg.yc) t = qg.yc;
        else if (b < qg.yc) b = qg.yc;
      end
      bl <= l; bt <= t; br <= r; bb <= b;
    end
  end

  // ---- output register, saturation
  function automatic abb_pkg::coord_t sat(input abb_pkg::ext_t v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      ok <= bg.ok;
      box_left <= bg.ok ? sat(bl) : '0;
      box_top <= bg.ok ? sat(bt) : '0;
      box_right <= bg.ok ? sat(br) : '0;
      box_bottom <= bg.ok ? sat(bb) : '0;
    end
  end

  // ---- checks
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(box_left) && $stable(ok))
    else $error("output moved under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input held without a waiting result");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> box_left == 0 && box_bottom == 0)
    else $error("rejected request with non-zero box");

endmodule
